// ----- design/lprt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lprt_pkg
// Shared sizes, codes and types of the longest-prefix route table.
// ----------------------------------------------------------------------------
package lprt_pkg;

	// Number of route slots.
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);

	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t LAST_IDX = idx_t'(DEPTH - 1);

	// Operation codes carried by the op field.
	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	// One stored route.
	typedef struct packed {
		logic [31:0]        prefix;
		logic [31:0]        mask;
		logic [31:0]        gateway;
		logic signed [15:0] port;
	} route_entry_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Sequencer controls.
	typedef struct packed {
		logic in_stall;
		logic scan_en;
		logic finish_go;
	} seq_ctrl_t;

endpackage : lprt_pkg
`default_nettype wire

// ----- design/lprt_route_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lprt_route_ram
// Route storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lprt_route_ram (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire lprt_pkg::idx_t        wr_addr,
	input  wire lprt_pkg::route_entry_t wr_data,
	input  wire logic                  rd_en,
	input  wire lprt_pkg::idx_t        rd_addr,
	output lprt_pkg::route_entry_t     rd_data
);
	import lprt_pkg::*;

	route_entry_t mem_q [DEPTH];
	route_entry_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule : lprt_route_ram
`default_nettype wire

// ----- design/longest_prefix_route_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// longest_prefix_route_table
// IPv4 route table with lookup, add and delete over a scanned slot memory.
// ----------------------------------------------------------------------------
// Every operation walks all DEPTH slots of the route memory, one slot per
// cycle through its single read port, and a single compare unit judges each
// slot as its data returns. After accept an item passes through the scan,
// a drain state that judges the last slot, a finish state that waits for
// the output register and idle before the next accept. in_stall is high
// for the whole walk. The result sits in an output register, so a new item
// may be taken while the previous result still waits on out_stall. Valid
// bits clear at reset; the route memory itself needs no clearing pass.
module longest_prefix_route_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input item channel.
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] address,
	input  wire logic [31:0] prefix_mask,
	input  wire logic [31:0] new_gateway,
	input  wire logic signed [15:0] new_port,
	// Result item channel.
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             found,
	output logic [31:0]      gateway,
	output logic signed [15:0] port,
	output logic             status
);
	import lprt_pkg::*;

	state_t    state_q;
	state_t    state_nxt;
	seq_ctrl_t ctrl;

	// Item held for the walk.
	logic [1:0]         op_q;
	logic [31:0]        addr_q;
	logic [31:0]        mask_q;
	logic [31:0]        gw_q;
	logic signed [15:0] port_q;

	// Scan counter and slot valid bits.
	idx_t             idx_q;
	logic [DEPTH-1:0] slot_valid_q;

	// Read stage tracking the slot whose data is coming out of the memory.
	logic act_s1;
	idx_t idx_s1;
	logic vld_s1;

	// Running results of the walk.
	logic               have_q;
	logic [31:0]        best_mask_q;
	logic [31:0]        best_gw_q;
	logic signed [15:0] best_port_q;
	logic               free_found_q;
	idx_t               free_idx_q;

	// Output register.
	logic               out_valid_q;
	logic               found_q;
	logic [31:0]        gateway_q;
	logic signed [15:0] port_oq;
	logic               status_q;

	route_entry_t rd_entry;
	route_entry_t wr_entry;
	logic         in_accept;
	logic         wr_en;
	logic         cmp_lookup_hit;
	logic         cmp_take;
	logic         cmp_delete_hit;

	assign in_accept = in_valid && !ctrl.in_stall;

	// Next state of the sequencer.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.in_stall = 1'b0;
			end
			ST_SCAN: begin
				ctrl.in_stall = 1'b1;
				ctrl.scan_en  = 1'b1;
			end
			ST_DRAIN: begin
				ctrl.in_stall = 1'b1;
			end
			ST_FINISH: begin
				ctrl.in_stall  = 1'b1;
				ctrl.finish_go = !out_valid_q || !out_stall;
			end
			default: begin
				ctrl.in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Route memory: read one slot per scan cycle, write once at the end of an add that found a free slot.
	assign wr_en            = ctrl.finish_go && (op_q == OP_ADD) && free_found_q;
	assign wr_entry.prefix  = addr_q & mask_q;
	assign wr_entry.mask    = mask_q;
	assign wr_entry.gateway = gw_q;
	assign wr_entry.port    = port_q;

	lprt_route_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (free_idx_q),
		.wr_data (wr_entry),
		.rd_en   (ctrl.scan_en),
		.rd_addr (idx_q),
		.rd_data (rd_entry)
	);

	// Capture the item on accept.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q   <= op;
			addr_q <= address;
			mask_q <= prefix_mask;
			gw_q   <= new_gateway;
			port_q <= new_port;
		end
	end

	// Scan counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (in_accept) begin
			idx_q <= '0;
		end else if (ctrl.scan_en) begin
			idx_q <= idx_q + idx_t'(1);
		end
	end

	// Read stage bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= ctrl.scan_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.scan_en) begin
			idx_s1 <= idx_q;
			vld_s1 <= slot_valid_q[idx_q];
		end
	end

	// Shared compare unit: judges the slot whose data has just been read.
	assign cmp_lookup_hit = act_s1 && vld_s1 && (op_q == OP_LOOKUP)
		&& ((addr_q & rd_entry.mask) == rd_entry.prefix);
	assign cmp_take = cmp_lookup_hit
		&& (!have_q || ((rd_entry.mask & best_mask_q) == best_mask_q));
	assign cmp_delete_hit = act_s1 && vld_s1 && (op_q == OP_DELETE)
		&& (rd_entry.prefix == addr_q) && (rd_entry.mask == mask_q);

	// Best match so far.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (in_accept) begin
			have_q <= 1'b0;
		end else if (cmp_take) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_take) begin
			best_mask_q <= rd_entry.mask;
			best_gw_q   <= rd_entry.gateway;
			best_port_q <= rd_entry.port;
		end
	end

	// Lowest free slot, found while the valid bits are walked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_found_q <= 1'b0;
		end else if (in_accept) begin
			free_found_q <= 1'b0;
		end else if (ctrl.scan_en && !free_found_q && !slot_valid_q[idx_q]) begin
			free_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.scan_en && !free_found_q && !slot_valid_q[idx_q]) begin
			free_idx_q <= idx_q;
		end
	end

	// Valid bits: cleared by delete during the walk, set by add at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else begin
			if (cmp_delete_hit) begin
				slot_valid_q[idx_s1] <= 1'b0;
			end
			if (wr_en) begin
				slot_valid_q[free_idx_q] <= 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish_go) begin
			found_q   <= have_q;
			gateway_q <= have_q ? best_gw_q : 32'd0;
			port_oq   <= have_q ? best_port_q : 16'sd0;
			status_q  <= (op_q == OP_ADD) && !free_found_q;
		end
	end

	assign in_stall  = ctrl.in_stall;
	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign gateway   = gateway_q;
	assign port      = port_oq;
	assign status    = status_q;

`ifndef ASSERT_OFF
	// The read stage is only busy during the walk.
	a_stage_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		act_s1 |-> (state_q == ST_DRAIN || state_q == ST_SCAN))
		else $error("read stage active outside the walk");

	// An add only ever writes a slot that is still free.
	a_add_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !slot_valid_q[free_idx_q])
		else $error("add overwrites a valid slot");

	// Finishing an item always leaves a result waiting.
	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish_go |=> out_valid)
		else $error("finished item left no result");

	// A lookup hit and a full table never show together.
	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && status))
		else $error("found and status both set");
`endif

endmodule : longest_prefix_route_table
`default_nettype wire

// ----- test/tb_longest_prefix_route_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_prefix_route_table
// Self-checking bench for the longest-prefix route table. It mirrors the table
// contents, predicts each lookup, add and delete as the item is taken, and
// checks every result item in order. The sender works in bursts and the
// receiver stalls on patterns of its own, one long hold-off among them.
// ----------------------------------------------------------------------------
module tb_longest_prefix_route_table;
	import lprt_pkg::*;

	// Code that the block treats as a no-op.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 60;

	// One result item as the block should present it.
	typedef struct packed {
		logic               found;
		logic [31:0]        gateway;
		logic signed [15:0] port;
		logic               status;
	} route_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [1:0] op = OP_LOOKUP;
	logic [31:0] address = '0;
	logic [31:0] prefix_mask = '0;
	logic [31:0] new_gateway = '0;
	logic signed [15:0] new_port = '0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic found;
	logic [31:0] gateway;
	logic signed [15:0] port;
	logic status;

	// Mirror of the route table.
	logic [31:0]        known_prefix [DEPTH];
	logic [31:0]        known_mask [DEPTH];
	logic [31:0]        known_gateway [DEPTH];
	logic signed [15:0] known_port [DEPTH];
	logic               known_used [DEPTH];

	route_result_t pending_results[$];
	int fail_count = 0;
	int result_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int sender_gap_max = 0;
	bit offering = 1'b0;
	int long_hold_len = 0;
	int hold_count = 0;
	int rx_mode = 0;
	int rx_left = 0;
	int rx_tick = 0;

	longest_prefix_route_table uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.address    (address),
		.prefix_mask(prefix_mask),
		.new_gateway(new_gateway),
		.new_port   (new_port),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.gateway    (gateway),
		.port       (port),
		.status     (status)
	);

	always #1 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Applies one operation to the mirror and returns the result it gives.
	function automatic route_result_t apply_route_op(input logic [1:0] code,
			input logic [31:0] addr, input logic [31:0] mask,
			input logic [31:0] gw, input logic signed [15:0] pidx);
		route_result_t res;
		logic have;
		logic placed;
		logic [31:0] best_mask;
		int best;
		res = '0;
		have = 1'b0;
		placed = 1'b0;
		best_mask = '0;
		best = 0;
		case (code)
			OP_LOOKUP: begin
				// A later match wins when its mask covers the best mask so far.
				for (int i = 0; i < DEPTH; i++) begin
					if (known_used[i] && (addr & known_mask[i]) == known_prefix[i] &&
							(!have || (known_mask[i] & best_mask) == best_mask)) begin
						have = 1'b1;
						best = i;
						best_mask = known_mask[i];
					end
				end
				if (have) begin
					res.found = 1'b1;
					res.gateway = known_gateway[best];
					res.port = known_port[best];
				end
			end
			OP_ADD: begin
				// Lowest free slot takes the route; a full table drops it.
				for (int i = 0; i < DEPTH; i++) begin
					if (!placed && !known_used[i]) begin
						placed = 1'b1;
						known_prefix[i] = addr & mask;
						known_mask[i] = mask;
						known_gateway[i] = gw;
						known_port[i] = pidx;
						known_used[i] = 1'b1;
					end
				end
				res.status = !placed;
			end
			OP_DELETE: begin
				for (int i = 0; i < DEPTH; i++) begin
					if (known_used[i] && known_prefix[i] == addr && known_mask[i] == mask)
						known_used[i] = 1'b0;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Offers one item, waits until it is taken, then records its result.
	task automatic send_route_op(input logic [1:0] code, input logic [31:0] addr,
			input logic [31:0] mask, input logic [31:0] gw,
			input logic signed [15:0] pidx);
		in_valid <= 1'b1;
		op <= code;
		address <= addr;
		prefix_mask <= mask;
		new_gateway <= gw;
		new_port <= pidx;
		offering = 1'b1;
		do @(posedge clk); while (in_stall);
		pending_results = {pending_results,
			apply_route_op(code, addr, mask, gw, pidx)};
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if (sender_gap_max > 0) begin
				in_valid <= 1'b0;
				offering = 1'b0;
				repeat ($urandom_range(1, sender_gap_max)) @(posedge clk);
			end
		end
	endtask

	// Withdraws the offer after the last item of a sequence.
	task automatic stop_sending();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic logic [31:0] random_mask();
		int len;
		len = $urandom_range(0, 32);
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		if (len == 0)
			return 32'h0;
		return 32'hFFFF_FFFF << (32 - len);
	endfunction

	// Most addresses fall in one small network so that routes overlap.
	function automatic logic [31:0] random_address();
		if ($urandom_range(0, 9) < 7)
			return {8'h0A, 8'($urandom_range(0, 3)), 16'($urandom)};
		return $urandom;
	endfunction

	function automatic int random_used_slot();
		int slots[$];
		for (int i = 0; i < DEPTH; i++)
			if (known_used[i])
				slots = {slots, i};
		if (slots.size() == 0)
			return -1;
		return slots[$urandom_range(0, slots.size() - 1)];
	endfunction

	// Empty table: no match, the unused code and a delete of nothing.
	task automatic test_empty_table();
		sender_gap_max = 3;
		send_route_op(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 16'sd5);
		send_route_op(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -16'sd1);
		send_route_op(OP_DELETE, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 16'sd0);
		stop_sending();
	endtask

	// Nested, equal and non-contiguous masks, masked adds and exact deletes.
	task automatic test_prefix_priority();
		sender_gap_max = 2;
		send_route_op(OP_ADD, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, -16'sd32768);
		send_route_op(OP_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 16'sd1);
		send_route_op(OP_ADD, 32'h0A01_FFFF, 32'hFFFF_0000, 32'h0A01_00FE, 16'sd32767);
		send_route_op(OP_ADD, 32'h0A01_0203, 32'hFFFF_FFFF, 32'h0000_0000, -16'sd1);
		send_route_op(OP_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FD, 16'sd2);
		send_route_op(OP_ADD, 32'h0001_0000, 32'h00FF_0000, 32'h0001_0001, 16'sd3);
		send_route_op(OP_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 16'sd0);
		send_route_op(OP_LOOKUP, 32'h0A01_0204, 32'hFFFF_FFFF, 32'h0, 16'sd0);
		send_route_op(OP_LOOKUP, 32'h0A02_0000, 32'h0, 32'h0, 16'sd0);
		send_route_op(OP_LOOKUP, 32'h0B01_0000, 32'h0, 32'h0, 16'sd0);
		send_route_op(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, -16'sd1);
		send_route_op(OP_LOOKUP, 32'h0A01_0000, 32'h0, 32'h0, 16'sd0);
		// The prefix is compared unmasked, so this delete hits nothing.
		send_route_op(OP_DELETE, 32'h0A01_FFFF, 32'hFFFF_0000, 32'h0, 16'sd0);
		send_route_op(OP_LOOKUP, 32'h0A01_AAAA, 32'h0, 32'h0, 16'sd0);
		// Both copies of the equal route go at once.
		send_route_op(OP_DELETE, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 16'sd0);
		send_route_op(OP_LOOKUP, 32'h0A02_0000, 32'h0, 32'h0, 16'sd0);
		stop_sending();
	endtask

	// Fills every slot, then tries to add beyond the end.
	task automatic test_table_full();
		sender_gap_max = 0;
		while (random_used_slot() >= 0 && !known_used.and()) begin
			send_route_op(OP_ADD, random_address(), random_mask(), $urandom,
				16'($urandom));
		end
		send_route_op(OP_ADD, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_0101, 16'sd7);
		send_route_op(OP_LOOKUP, 32'hC0A8_0105, 32'h0, 32'h0, 16'sd0);
		stop_sending();
	endtask

	// The receiver holds off while items keep coming, so the block backs up.
	task automatic test_result_backpressure();
		sender_gap_max = 0;
		long_hold_len = 300;
		for (int n = 0; n < 12; n++) begin
			send_route_op(OP_LOOKUP, random_address(), $urandom, $urandom,
				16'($urandom));
		end
		stop_sending();
	endtask

	// Mixed traffic; deletes and lookups mostly aim at routes in the table.
	task automatic test_random_traffic(input int items, input int add_pct,
			input int del_pct, input int gap_max);
		int roll;
		int slot;
		logic [1:0] code;
		logic [31:0] addr;
		logic [31:0] mask;
		sender_gap_max = gap_max;
		for (int n = 0; n < items; n++) begin
			roll = $urandom_range(0, 99);
			addr = random_address();
			mask = random_mask();
			slot = random_used_slot();
			if (roll < 3) begin
				code = OP_UNUSED;
			end else if (roll < 3 + add_pct) begin
				code = OP_ADD;
			end else if (roll < 3 + add_pct + del_pct) begin
				code = OP_DELETE;
				if (slot >= 0 && $urandom_range(0, 3) != 0) begin
					addr = known_prefix[slot];
					mask = known_mask[slot];
				end
			end else begin
				code = OP_LOOKUP;
				if (slot >= 0 && $urandom_range(0, 2) != 0)
					addr = known_prefix[slot] | ($urandom & ~known_mask[slot]);
			end
			send_route_op(code, addr, mask, $urandom, 16'($urandom));
		end
		stop_sending();
	endtask

	// Receiver stall patterns, with a long hold-off on request.
	always @(posedge clk) begin
		if (long_hold_len != 0) begin
			hold_count = long_hold_len;
			long_hold_len = 0;
		end
		if (hold_count != 0) begin
			out_stall <= 1'b1;
			hold_count--;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(20, 300);
			end
			rx_left--;
			rx_tick++;
			case (rx_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 1);
				2: out_stall <= (rx_tick % 5 < 2);
				default: out_stall <= ($urandom_range(0, 9) < 8);
			endcase
		end
	end

	// Compares each taken result item with the oldest prediction.
	always @(posedge clk) begin : check_results
		route_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("Result %0d arrived with nothing pending: found=%0b gateway=%h port=%0d status=%0b",
						result_count, found, gateway, port, status);
			end else begin
				want = pending_results.pop_front();
				if (found !== want.found || gateway !== want.gateway ||
						port !== want.port || status !== want.status) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Result %0d mismatch: expected found=%0b gateway=%h port=%0d status=%0b, got found=%0b gateway=%h port=%0d status=%0b",
							result_count, want.found, want.gateway, want.port, want.status,
							found, gateway, port, status);
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			known_prefix[i] = '0;
			known_mask[i] = '0;
			known_gateway[i] = '0;
			known_port[i] = '0;
			known_used[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_prefix_priority();
		test_table_full();
		test_result_backpressure();
		test_random_traffic(600, 45, 10, 4);
		test_random_traffic(500, 15, 40, 0);
		test_random_traffic(600, 30, 27, 8);

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
